FILE: hw/rtl/gwic_pkg.sv
// ============================================================================
// gwic_pkg - shared types and constants for the GPIO wake interrupt controller
// Pin count, register word map, request opcodes and the register view struct.
// ============================================================================
package gwic_pkg;

    localparam int NUM_PINS   = 8;                  // 1..8, bounded by data width
    localparam int DATA_W     = 8;
    localparam int WORD_W     = 6;
    localparam int LOW_W      = $clog2(DATA_W);
    localparam int NUM_GROUPS = 6;

    // request opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // word map (byte offset - 0x800) / 4
    localparam logic [WORD_W-1:0] WORD_GATE      = 6'd0;   // 0x800
    localparam logic [WORD_W-1:0] WORD_MODE_BASE = 6'd7;   // 0x81C, clr/set/read per group
    localparam logic [WORD_W-1:0] WORD_PEND      = 6'd25;  // 0x864

    // mode groups, in word map order
    localparam int GRP_FALL = 0;
    localparam int GRP_RISE = 1;
    localparam int GRP_LOW  = 2;
    localparam int GRP_HIGH = 3;
    localparam int GRP_DET  = 4;
    localparam int GRP_IRQ  = 5;

    typedef logic [NUM_PINS-1:0]                 t_pins;
    typedef logic [NUM_GROUPS-1:0][NUM_PINS-1:0] t_mode_bank;

    // post-request view of the register file
    typedef struct packed {
        logic [DATA_W-1:0] rd_data;
        t_pins             pending;
        t_pins             int_en;
    } t_reg_view;

endpackage

FILE: hw/rtl/gwic_regfile.sv
// ============================================================================
// gwic_regfile - gate, mode, enable and pending registers
// Applies one bus read, bus write or pin sample tick per advance.
// ============================================================================
module gwic_regfile
    import gwic_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [1:0]        i_opcode,
    input  logic [WORD_W-1:0] i_reg_word,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [DATA_W-1:0] i_pin_levels,
    output t_reg_view         o_view
);

    logic       r_gate, n_gate;
    t_mode_bank r_mode, n_mode;
    t_pins      r_pending, n_pending;
    t_pins      r_prev, n_prev;

    logic [DATA_W-1:0] rd;
    t_pins             bits;
    t_pins             cur;
    t_pins             ev;

    always_comb begin
        n_gate    = r_gate;
        n_mode    = r_mode;
        n_pending = r_pending;
        n_prev    = r_prev;
        rd        = '0;
        bits      = i_write_data[NUM_PINS-1:0];
        cur       = i_pin_levels[NUM_PINS-1:0];
        ev        = (r_prev & ~cur & r_mode[GRP_FALL])
                  | (~r_prev & cur & r_mode[GRP_RISE])
                  | (~cur & r_mode[GRP_LOW])
                  | (cur & r_mode[GRP_HIGH]);
        unique case (i_opcode)
            OP_READ: begin
                if (i_reg_word == WORD_GATE) begin
                    rd = DATA_W'(r_gate);
                end
                if (i_reg_word == WORD_PEND) begin
                    rd = DATA_W'(r_pending);
                end
                for (int g = 0; g < NUM_GROUPS; g++) begin
                    if (i_reg_word == WORD_MODE_BASE + WORD_W'(3 * g + 2)) begin
                        rd = DATA_W'(r_mode[g]);
                    end
                end
            end
            OP_WRITE: begin
                if (i_reg_word == WORD_GATE) begin
                    n_gate = i_write_data[0];
                end else if (r_gate) begin
                    if (i_reg_word == WORD_PEND) begin
                        n_pending = r_pending & ~bits;  // write one to clear
                    end
                    for (int g = 0; g < NUM_GROUPS; g++) begin
                        if (i_reg_word == WORD_MODE_BASE + WORD_W'(3 * g)) begin
                            n_mode[g] = r_mode[g] & ~bits;
                        end
                        if (i_reg_word == WORD_MODE_BASE + WORD_W'(3 * g + 1)) begin
                            n_mode[g] = r_mode[g] | bits;
                        end
                    end
                end
            end
            OP_TICK: begin
                n_pending = r_pending | (ev & r_mode[GRP_DET]);
                n_prev    = cur;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate    <= 1'b0;
            r_mode    <= '0;
            r_pending <= '0;
            r_prev    <= '0;
        end else if (i_advance) begin
            r_gate    <= n_gate;
            r_mode    <= n_mode;
            r_pending <= n_pending;
            r_prev    <= n_prev;
        end
    end

    assign o_view.rd_data = rd;
    assign o_view.pending = n_pending;
    assign o_view.int_en  = n_mode[GRP_IRQ];

endmodule

FILE: hw/rtl/gwic_status.sv
// ============================================================================
// gwic_status - interrupt line and pending summary
// Reduces the post-request pending and enable bits to the status fields.
// ============================================================================
module gwic_status
    import gwic_pkg::*;
(
    input  t_reg_view        i_view,
    output logic             o_irq,
    output logic             o_any,
    output logic [LOW_W-1:0] o_lowest
);

    always_comb begin
        o_irq    = |(i_view.pending & i_view.int_en);
        o_any    = |i_view.pending;
        o_lowest = '0;
        // scan down so the lowest set bit wins
        for (int i = NUM_PINS - 1; i >= 0; i--) begin
            if (i_view.pending[i]) begin
                o_lowest = LOW_W'(i);
            end
        end
    end

endmodule

FILE: hw/rtl/gpio_wake_interrupt_controller.sv
// ============================================================================
// gpio_wake_interrupt_controller - always-on GPIO wake interrupt detector
// Input register, regfile update, result register; one request/cycle if not stalled.
// ============================================================================
// The result is valid once the request has moved into the result register.
// Throughput: one request per cycle unless the result side stalls; the regfile
//   updates as the request moves from the input into the result register.
// Reset: i_rst_n synchronous active low; clears both stage valids and all
//   register file state (gate closed, modes, enables, pending and last levels zero).
module gpio_wake_interrupt_controller
    import gwic_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [WORD_W-1:0] i_reg_word,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [DATA_W-1:0] i_pin_levels,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_irq_out,
    output logic              o_any_pending,
    output logic [LOW_W-1:0]  o_lowest_pending
);

    // ---- input register ----------------------------------------------------
    logic              r_s1_valid;
    logic [1:0]        r_s1_op;
    logic [WORD_W-1:0] r_s1_word;
    logic [DATA_W-1:0] r_s1_data;
    logic [DATA_W-1:0] r_s1_levels;

    // ---- result register ---------------------------------------------------
    logic              r_out_valid;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_irq;
    logic              r_any;
    logic [LOW_W-1:0]  r_lowest;

    logic              s1_advance;   // request moves into the result register
    t_reg_view         view;
    logic              st_irq;
    logic              st_any;
    logic [LOW_W-1:0]  st_lowest;

    // The result register is free when empty or being drained this cycle.
    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_op     <= i_opcode;
            r_s1_word   <= i_reg_word;
            r_s1_data   <= i_write_data;
            r_s1_levels <= i_pin_levels;
        end
    end

    // Register file: state commits only when the request advances, so a
    // stalled request is applied exactly once.
    gwic_regfile u_regfile (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (s1_advance),
        .i_opcode     (r_s1_op),
        .i_reg_word   (r_s1_word),
        .i_write_data (r_s1_data),
        .i_pin_levels (r_s1_levels),
        .o_view       (view)
    );

    // Status is taken from the state after this request.
    gwic_status u_status (
        .i_view   (view),
        .o_irq    (st_irq),
        .o_any    (st_any),
        .o_lowest (st_lowest)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_rd_data <= view.rd_data;
            r_irq     <= st_irq;
            r_any     <= st_any;
            r_lowest  <= st_lowest;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_rd_data;
    assign o_irq_out        = r_irq;
    assign o_any_pending    = r_any;
    assign o_lowest_pending = r_lowest;

    // ---- assertions ----------------------------------------------------------
    // Interrupt needs something pending.
    a_irq_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_any) |-> !r_irq)
        else $error("irq raised with nothing pending");

    // Lowest index is zero when nothing is pending.
    a_lowest_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_any) |-> (r_lowest == '0))
        else $error("lowest pending nonzero with nothing pending");

    // Full pipeline with a stalled result must not take a new request.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request accepted while pipeline full");

    // Gate read carries a single bit.
    a_gate_read_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && r_s1_op == OP_READ && r_s1_word == WORD_GATE)
        |=> (r_rd_data[DATA_W-1:1] == '0))
        else $error("gate read returned upper bits");

endmodule

FILE: bench/gwic_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// gwic_checker - request/result scoreboard for the GPIO wake interrupt block
// Mirrors the gate, mode banks, pending bits and last pin levels, predicts
// the status of every accepted request and compares it with the results.
// ============================================================================
module gwic_checker
    import gwic_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [WORD_W-1:0] i_reg_word,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [DATA_W-1:0] i_pin_levels,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [DATA_W-1:0] i_read_data,
    input  logic              i_irq_out,
    input  logic              i_any_pending,
    input  logic [LOW_W-1:0]  i_lowest_pending,
    output int                o_fail_count,
    output int                o_due_count
);

    // position of a word inside its clear/set/read triple
    localparam int SUB_CLR    = 0;
    localparam int SUB_SET    = 1;
    localparam int SUB_RD     = 2;
    localparam int SUB_WORDS  = 3;
    localparam int MODE_WORDS = NUM_GROUPS * SUB_WORDS;

    typedef struct packed {
        logic [DATA_W-1:0] rd_data;
        logic              irq;
        logic              pend_any;
        logic [LOW_W-1:0]  pend_low;
    } t_status;

    logic       gate_q;
    t_mode_bank mode_q;
    t_pins      pend_q;
    t_pins      last_lvl_q;
    t_status    status_due[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        $display("%0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    // apply one request to the mirrored registers, return the status after it
    task automatic apply_request(input logic [1:0] op, input logic [WORD_W-1:0] word,
                                 input logic [DATA_W-1:0] wdata,
                                 input logic [DATA_W-1:0] lvl, output t_status st);
        t_pins bits;
        t_pins cur;
        t_pins evt;
        int    rel;
        int    grp;
        int    sub;
        bits = wdata[NUM_PINS-1:0];
        st   = '0;
        rel  = int'(word) - int'(WORD_MODE_BASE);
        grp  = (rel >= 0) ? rel / SUB_WORDS : 0;
        sub  = (rel >= 0) ? rel % SUB_WORDS : 0;
        case (op)
            OP_READ: begin
                if (word == WORD_GATE)
                    st.rd_data[0] = gate_q;
                else if (rel >= 0 && rel < MODE_WORDS && sub == SUB_RD)
                    st.rd_data[NUM_PINS-1:0] = mode_q[grp];
                else if (word == WORD_PEND)
                    st.rd_data[NUM_PINS-1:0] = pend_q;
            end
            OP_WRITE: begin
                if (word == WORD_GATE) begin
                    gate_q = wdata[0];
                end else if (gate_q) begin
                    if (rel >= 0 && rel < MODE_WORDS) begin
                        if (sub == SUB_CLR)
                            mode_q[grp] = mode_q[grp] & ~bits;
                        else if (sub == SUB_SET)
                            mode_q[grp] = mode_q[grp] | bits;
                    end else if (word == WORD_PEND) begin
                        pend_q = pend_q & ~bits;
                    end
                end
            end
            OP_TICK: begin
                cur = lvl[NUM_PINS-1:0];
                evt = (last_lvl_q & ~cur & mode_q[GRP_FALL])
                    | (~last_lvl_q & cur & mode_q[GRP_RISE])
                    | (~cur & mode_q[GRP_LOW])
                    | (cur & mode_q[GRP_HIGH]);
                pend_q     = pend_q | (evt & mode_q[GRP_DET]);
                last_lvl_q = cur;
            end
            default: ;
        endcase
        st.irq      = |(pend_q & mode_q[GRP_IRQ]);
        st.pend_any = |pend_q;
        for (int i = NUM_PINS - 1; i >= 0; i--)
            if (pend_q[i])
                st.pend_low = LOW_W'(i);
    endtask

    always @(posedge i_clk) begin : watch
        t_status due;
        t_status fresh;
        if (!i_rst_n) begin
            gate_q     = 1'b0;
            mode_q     = '0;
            pend_q     = '0;
            last_lvl_q = '0;
            status_due.delete();
        end else begin
            // results first: anything accepted here belongs to an older request
            if (i_out_valid && i_out_ready) begin
                if (status_due.size() == 0) begin
                    report_mismatch("result with no request waiting, read_data",
                                    i_read_data, 0);
                end else begin
                    due = status_due.pop_front();
                    if (i_read_data != due.rd_data)
                        report_mismatch("read_data", i_read_data, due.rd_data);
                    if (i_irq_out != due.irq)
                        report_mismatch("irq_out", i_irq_out, due.irq);
                    if (i_any_pending != due.pend_any)
                        report_mismatch("any_pending", i_any_pending, due.pend_any);
                    if (i_lowest_pending != due.pend_low)
                        report_mismatch("lowest_pending", i_lowest_pending, due.pend_low);
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_request(i_opcode, i_reg_word, i_write_data, i_pin_levels, fresh);
                status_due.push_back(fresh);
            end
        end
        o_due_count <= status_due.size();
    end

endmodule

FILE: bench/gpio_wake_interrupt_controller_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// gpio_wake_interrupt_controller_tb - top-level bench for the wake controller
// Drives register reads, writes and pin ticks with random idling and stalls;
// the checker beside the block predicts and compares every result.
// ============================================================================
module gpio_wake_interrupt_controller_tb;
    import gwic_pkg::*;

    // opcode the block must treat as a no-op
    localparam logic [1:0]        OP_IDLE     = 2'd3;
    localparam logic [WORD_W-1:0] WORD_TOP    = {WORD_W{1'b1}};
    localparam int                RANDOM_REQS = 900;
    localparam int                PHASES      = 4;
    localparam int                BURST_REQS  = 40;     // offered during the long hold
    localparam int                HOLD_CYCLES = 300;    // receiver hold-off length
    localparam int                DRAIN_WAIT  = 8;      // settling margin after the drain
    localparam int                CYCLE_LIMIT = 100000;

    // per-phase idle/stall percentages: none, sender, receiver, both
    localparam int IDLE_PLAN[PHASES]  = '{0, 77, 0, 34};
    localparam int STALL_PLAN[PHASES] = '{0, 0, 77, 34};

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic [1:0]        i_opcode     = OP_READ;
    logic [WORD_W-1:0] i_reg_word   = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic [DATA_W-1:0] i_pin_levels = '0;
    logic              i_out_ready  = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [DATA_W-1:0] o_read_data;
    logic              o_irq_out;
    logic              o_any_pending;
    logic [LOW_W-1:0]  o_lowest_pending;

    int                fail_count;
    int                due_count;
    int                idle_pct  = 0;
    int                stall_pct = 0;
    int                cycle_cnt = 0;
    bit                hold_ask  = 1'b0;    // raised by stimulus
    bit                hold_done = 1'b0;    // set by receiver once the hold has started
    logic [DATA_W-1:0] lvl_now   = '0;      // pin levels carried request to request

    gpio_wake_interrupt_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_reg_word       (i_reg_word),
        .i_write_data     (i_write_data),
        .i_pin_levels     (i_pin_levels),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_read_data      (o_read_data),
        .o_irq_out        (o_irq_out),
        .o_any_pending    (o_any_pending),
        .o_lowest_pending (o_lowest_pending)
    );

    gwic_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_reg_word       (i_reg_word),
        .i_write_data     (i_write_data),
        .i_pin_levels     (i_pin_levels),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_read_data      (o_read_data),
        .i_irq_out        (o_irq_out),
        .i_any_pending    (o_any_pending),
        .i_lowest_pending (o_lowest_pending),
        .o_fail_count     (fail_count),
        .o_due_count      (due_count)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Result side: random stalls per the current phase. A hold request parks
    // ready low for a long stretch so the pipe backs up into the request side.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_ask && !hold_done) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one request and hold it until taken. Valid stays up into the next
    // request unless an idle gap is drawn, so it never drops and rises in one step.
    task automatic send_req(input logic [1:0] op, input logic [WORD_W-1:0] word,
                            input logic [DATA_W-1:0] wdata);
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_reg_word   <= word;
        i_write_data <= wdata;
        i_pin_levels <= lvl_now;
        do @(posedge i_clk); while (!o_in_ready);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Random request, weighted toward the mode/enable/pending words so the gate
    // mostly stays open and detection gets exercised. Pin levels usually flip a
    // single pin so edges stay meaningful; sometimes they jump anywhere.
    task automatic send_random_req();
        int                roll;
        int                pin;
        logic [1:0]        op;
        logic [WORD_W-1:0] word;
        logic [DATA_W-1:0] wdata;
        roll = $urandom_range(99);
        if (roll < 35)      op = OP_TICK;
        else if (roll < 62) op = OP_WRITE;
        else if (roll < 97) op = OP_READ;
        else                op = OP_IDLE;
        roll = $urandom_range(99);
        if (roll < 6)       word = WORD_GATE;
        else if (roll < 92) word = WORD_W'($urandom_range(WORD_MODE_BASE, WORD_PEND));
        else                word = WORD_W'($urandom_range(WORD_TOP));
        wdata = DATA_W'($urandom);
        // gate writes mostly reopen; the odd one closes it for a while
        if (op == OP_WRITE && word == WORD_GATE && $urandom_range(4) != 0)
            wdata[0] = 1'b1;
        if ($urandom_range(3) == 0) begin
            lvl_now = DATA_W'($urandom);
        end else begin
            pin          = $urandom_range(DATA_W - 1);
            lvl_now[pin] = ~lvl_now[pin];
        end
        send_req(op, word, wdata);
    endtask

    initial begin
        // synchronous reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        send_req(OP_READ, WORD_GATE, '0);              // gate reads closed
        send_req(OP_WRITE, WORD_MODE_BASE + WORD_W'(1), '1); // closed gate: ignored
        send_req(OP_WRITE, WORD_GATE, 8'hFE);          // only bit 0 counts: stays shut
        send_req(OP_WRITE, WORD_GATE, 8'h01);          // open
        // sweep every mode word with all ones: clear then set per group,
        // read words ignore writes; leaves all modes and enables on
        for (int w = WORD_MODE_BASE; w < WORD_PEND; w++)
            send_req(OP_WRITE, WORD_W'(w), '1);
        lvl_now = '1;
        send_req(OP_TICK, '0, '0);                     // first tick high counts as rising
        send_req(OP_WRITE, WORD_PEND, 8'h0F);          // clear low pins
        send_req(OP_TICK, '0, '0);                     // high level latches them again
        lvl_now = '0;
        send_req(OP_TICK, '0, '0);                     // falling plus low level
        send_req(OP_IDLE, WORD_PEND, '1);              // opcode three: no effect
        send_req(OP_READ, WORD_TOP, '0);               // unmodelled word reads zero
        send_req(OP_WRITE, WORD_GATE, '0);             // close
        send_req(OP_WRITE, WORD_PEND, '1);             // pending clear blocked

        // ---- random phases ----
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct  = IDLE_PLAN[ph];
            stall_pct = STALL_PLAN[ph];
            send_req(OP_WRITE, WORD_GATE, 8'h01);
            if (ph == 0) begin
                // long receiver hold while requests keep coming back to back
                hold_ask = 1'b1;
                repeat (BURST_REQS) send_random_req();
                repeat (RANDOM_REQS / PHASES - BURST_REQS) send_random_req();
            end else begin
                repeat (RANDOM_REQS / PHASES) send_random_req();
            end
        end

        // ---- drain ----
        i_in_valid <= 1'b0;
        @(posedge i_clk);                              // let the last push show up
        while (due_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/gwic_pkg.sv
hw/rtl/gwic_regfile.sv
hw/rtl/gwic_status.sv
hw/rtl/gpio_wake_interrupt_controller.sv
bench/gwic_checker.sv
bench/gpio_wake_interrupt_controller_tb.sv
